FILE: hw/rtl/pivff_pkg.sv
// Shared types, constants and register codes for the PI voltage loop.
// Used by pivff_ctrl, pivff_dp and pi_voltage_loop_with_feedforward.
package pivff_pkg;

  localparam int VOLT_W    = 16;
  localparam int ACC_FRAC  = 16;
  localparam int GAIN_FRAC = 24;
  localparam int GAIN_SHR  = GAIN_FRAC - ACC_FRAC;
  localparam int GAIN_W    = 32;
  localparam int CNT16_W   = 16;
  localparam int ERR_W     = VOLT_W + 1;
  localparam int DERR_W    = VOLT_W + 2;
  localparam int ACC_W     = 17 + ACC_FRAC;
  localparam int PROD_W    = GAIN_W + 1 + DERR_W;
  localparam int PSUM_W    = PROD_W + 1;
  localparam int INC_W     = PSUM_W - GAIN_SHR;
  localparam int ASUM_W    = INC_W + 1;
  localparam int NUM_W     = CNT16_W + VOLT_W;
  localparam int QUO_W     = 19 + ACC_FRAC;
  localparam int OVF_SHL   = QUO_W - ACC_FRAC;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int SUM_W     = QUO_W + 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [GAIN_W-1:0]  KP_RST  = 32'd3355443;
  localparam logic [GAIN_W-1:0]  KI_RST  = 32'd12905;
  localparam logic [CNT16_W-1:0] LIM_RST = 16'd100;
  localparam logic [CNT16_W-1:0] PER_RST = 16'd1000;

  // feed-forward cap: 2^18 counts
  localparam logic [QUO_W-1:0] FF_CAP       = {1'b1, {(QUO_W-1){1'b0}}};
  localparam logic [QUO_W-1:0] FF_CAP_THRSH = FF_CAP | (QUO_W'(1) << ACC_FRAC);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 2'd0,
    CFG_INT_GAIN   = 2'd1,
    CFG_CTRL_LIMIT = 2'd2,
    CFG_PWM_PERIOD = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [VOLT_W-1:0] ref_voltage;
    logic [VOLT_W-1:0] feedback_voltage;
    logic [VOLT_W-1:0] bus_voltage;
  } in_item_t;

  typedef struct packed {
    logic [CNT16_W-1:0] duty_count;
    logic               loop_clamped;
    logic               duty_clamped;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_I,
    S_ADD,
    S_ACC,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_p;
    logic mul_i;
    logic add;
    logic acc_upd;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_skip;
  } status_t;

endpackage

FILE: hw/rtl/pivff_dp.sv
// Datapath: config registers, shared gain multiplier, PI accumulator,
// restoring divider for the feed-forward term and the output register.
// Depends on pivff_pkg.
module pivff_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [pivff_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pivff_pkg::GAIN_W-1:0] cfg_wdata,
  input  pivff_pkg::in_item_t          in_data,
  input  pivff_pkg::cmd_t              cmd,
  output pivff_pkg::status_t           status,
  output pivff_pkg::out_item_t         out_data
);

  logic [pivff_pkg::GAIN_W-1:0]  kp_r, ki_r;
  logic [pivff_pkg::CNT16_W-1:0] lim_r, per_r;

  logic [pivff_pkg::VOLT_W-1:0]        ref_r, bus_r;
  logic signed [pivff_pkg::ERR_W-1:0]  err_r, prev_err_r;
  logic signed [pivff_pkg::DERR_W-1:0] derr_r;
  logic signed [pivff_pkg::PROD_W-1:0] mul_r, prod_r;
  logic signed [pivff_pkg::INC_W-1:0]  inc_r;
  logic signed [pivff_pkg::ACC_W-1:0]  pi_acc_r;
  logic                                loop_flag_r;
  logic [pivff_pkg::NUM_W-1:0]         num_r;
  logic                                zero_r, ovf_r;
  logic [pivff_pkg::CNT16_W-1:0]       rem_r;
  logic [pivff_pkg::QUO_W-1:0]         quo_r;
  pivff_pkg::out_item_t                out_r;

  logic signed [pivff_pkg::ERR_W-1:0]  err_c;
  logic signed [pivff_pkg::DERR_W-1:0] derr_c;
  logic signed [pivff_pkg::GAIN_W:0]   mul_a;
  logic signed [pivff_pkg::DERR_W-1:0] mul_b;
  logic signed [pivff_pkg::PSUM_W-1:0] psum_c;
  logic signed [pivff_pkg::ASUM_W-1:0] asum_c, lim_s, nlim_s;
  logic [pivff_pkg::CNT16_W:0]         dtry_c, ddiff_c;
  logic                                dge_c;
  logic [pivff_pkg::QUO_W-1:0]         ff_c;
  logic signed [pivff_pkg::SUM_W-1:0]  sum_c, per_s;
  logic signed [pivff_pkg::SUM_W-1:0]  sum_cl;
  logic                                duty_flag_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= pivff_pkg::KP_RST;
      ki_r  <= pivff_pkg::KI_RST;
      lim_r <= pivff_pkg::LIM_RST;
      per_r <= pivff_pkg::PER_RST;
    end else if (cfg_wr_en) begin
      unique case (pivff_pkg::cfg_idx_t'(cfg_index))
        pivff_pkg::CFG_PROP_GAIN:  kp_r  <= cfg_wdata;
        pivff_pkg::CFG_INT_GAIN:   ki_r  <= cfg_wdata;
        pivff_pkg::CFG_CTRL_LIMIT: lim_r <= cfg_wdata[pivff_pkg::CNT16_W-1:0];
        pivff_pkg::CFG_PWM_PERIOD: per_r <= cfg_wdata[pivff_pkg::CNT16_W-1:0];
        default: ;
      endcase
    end
  end

  assign err_c  = $signed({1'b0, in_data.ref_voltage}) -
                  $signed({1'b0, in_data.feedback_voltage});
  assign derr_c = $signed({err_c[pivff_pkg::ERR_W-1], err_c}) -
                  $signed({prev_err_r[pivff_pkg::ERR_W-1], prev_err_r});

  assign mul_a = cmd.mul_i ? $signed({1'b0, ki_r}) : $signed({1'b0, kp_r});
  assign mul_b = cmd.mul_i ? $signed({err_r[pivff_pkg::ERR_W-1], err_r}) : derr_r;

  assign psum_c = $signed({prod_r[pivff_pkg::PROD_W-1], prod_r}) +
                  $signed({mul_r[pivff_pkg::PROD_W-1], mul_r});

  assign asum_c = $signed({{(pivff_pkg::ASUM_W-pivff_pkg::ACC_W){pi_acc_r[pivff_pkg::ACC_W-1]}},
                           pi_acc_r}) +
                  $signed({inc_r[pivff_pkg::INC_W-1], inc_r});
  assign lim_s  = $signed({{(pivff_pkg::ASUM_W-pivff_pkg::CNT16_W-pivff_pkg::ACC_FRAC){1'b0}},
                           lim_r, {pivff_pkg::ACC_FRAC{1'b0}}});
  assign nlim_s = -lim_s;

  // one restoring-division step
  assign dtry_c  = {rem_r, quo_r[pivff_pkg::QUO_W-1]};
  assign dge_c   = dtry_c >= {1'b0, bus_r};
  assign ddiff_c = dtry_c - {1'b0, bus_r};

  always_comb begin
    priority if (zero_r) begin
      ff_c = {{(pivff_pkg::QUO_W-pivff_pkg::CNT16_W-pivff_pkg::ACC_FRAC){1'b0}},
              per_r, {pivff_pkg::ACC_FRAC{1'b0}}};
    end else if (ovf_r || quo_r >= pivff_pkg::FF_CAP_THRSH) begin
      ff_c = pivff_pkg::FF_CAP;
    end else begin
      ff_c = quo_r;
    end
  end

  assign sum_c = $signed({{(pivff_pkg::SUM_W-pivff_pkg::ACC_W){pi_acc_r[pivff_pkg::ACC_W-1]}},
                          pi_acc_r}) +
                 $signed({2'b00, ff_c});
  assign per_s = $signed({{(pivff_pkg::SUM_W-pivff_pkg::CNT16_W-pivff_pkg::ACC_FRAC){1'b0}},
                          per_r, {pivff_pkg::ACC_FRAC{1'b0}}});

  always_comb begin
    duty_flag_c = 1'b1;
    priority if (sum_c > per_s) begin
      sum_cl = per_s;
    end else if (sum_c < 0) begin
      sum_cl = '0;
    end else begin
      sum_cl      = sum_c;
      duty_flag_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      pi_acc_r   <= '0;
    end else begin
      if (cmd.load) begin
        prev_err_r <= err_c;
      end
      if (cmd.acc_upd) begin
        priority if (asum_c > lim_s) begin
          pi_acc_r <= lim_s[pivff_pkg::ACC_W-1:0];
        end else if (asum_c < nlim_s) begin
          pi_acc_r <= nlim_s[pivff_pkg::ACC_W-1:0];
        end else begin
          pi_acc_r <= asum_c[pivff_pkg::ACC_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ref_r  <= in_data.ref_voltage;
      bus_r  <= in_data.bus_voltage;
      err_r  <= err_c;
      derr_r <= derr_c;
    end
    if (cmd.mul_p || cmd.mul_i) begin
      mul_r <= mul_a * mul_b;
    end
    if (cmd.mul_p) begin
      num_r <= per_r * ref_r;
    end
    if (cmd.mul_i) begin
      prod_r <= mul_r;
    end
    if (cmd.add) begin
      inc_r  <= psum_c[pivff_pkg::PSUM_W-1:pivff_pkg::GAIN_SHR];
      zero_r <= bus_r == '0;
      ovf_r  <= {{(pivff_pkg::QUO_W-pivff_pkg::NUM_W){1'b0}}, num_r} >=
                {bus_r, {pivff_pkg::OVF_SHL{1'b0}}};
      rem_r  <= {{(pivff_pkg::CNT16_W-pivff_pkg::NUM_W+pivff_pkg::OVF_SHL){1'b0}},
                 num_r[pivff_pkg::NUM_W-1:pivff_pkg::OVF_SHL]};
      quo_r  <= {num_r[pivff_pkg::OVF_SHL-1:0], {pivff_pkg::ACC_FRAC{1'b0}}};
    end
    if (cmd.acc_upd) begin
      loop_flag_r <= (asum_c > lim_s) || (asum_c < nlim_s);
    end
    if (cmd.div_step) begin
      rem_r <= dge_c ? ddiff_c[pivff_pkg::CNT16_W-1:0] : dtry_c[pivff_pkg::CNT16_W-1:0];
      quo_r <= {quo_r[pivff_pkg::QUO_W-2:0], dge_c};
    end
    if (cmd.emit) begin
      out_r.duty_count   <= sum_cl[pivff_pkg::ACC_FRAC+pivff_pkg::CNT16_W-1:pivff_pkg::ACC_FRAC];
      out_r.loop_clamped <= loop_flag_r;
      out_r.duty_clamped <= duty_flag_c;
    end
  end

  assign status.div_skip = zero_r || ovf_r;
  assign out_data        = out_r;

endmodule

FILE: hw/rtl/pivff_ctrl.sv
// Controller FSM: sequences the datapath and owns both channel handshakes.
// Depends on pivff_pkg.
module pivff_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pivff_pkg::status_t  status,
  output pivff_pkg::cmd_t     cmd
);

  pivff_pkg::state_t             state_r, state_nxt;
  logic [pivff_pkg::CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pivff_pkg::S_IDLE:  if (in_valid) state_nxt = pivff_pkg::S_MUL_P;
      pivff_pkg::S_MUL_P: state_nxt = pivff_pkg::S_MUL_I;
      pivff_pkg::S_MUL_I: state_nxt = pivff_pkg::S_ADD;
      pivff_pkg::S_ADD:   state_nxt = pivff_pkg::S_ACC;
      pivff_pkg::S_ACC: begin
        state_nxt = status.div_skip ? pivff_pkg::S_EMIT : pivff_pkg::S_DIV;
      end
      pivff_pkg::S_DIV: begin
        if (div_cnt_r == pivff_pkg::CNT_W'(pivff_pkg::DIV_STEPS - 1)) begin
          state_nxt = pivff_pkg::S_EMIT;
        end
      end
      pivff_pkg::S_EMIT:  if (out_free) state_nxt = pivff_pkg::S_IDLE;
      default:            state_nxt = pivff_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_stall      = 1'b1;
    div_cnt_nxt   = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      pivff_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      pivff_pkg::S_MUL_P: cmd.mul_p   = 1'b1;
      pivff_pkg::S_MUL_I: cmd.mul_i   = 1'b1;
      pivff_pkg::S_ADD:   cmd.add     = 1'b1;
      pivff_pkg::S_ACC:   cmd.acc_upd = 1'b1;
      pivff_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
      end
      pivff_pkg::S_EMIT: begin
        cmd.emit = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pivff_pkg::S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == pivff_pkg::S_MUL_P)
    else $error("accepted transaction did not start the multiply");

  a_div_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pivff_pkg::S_DIV |-> div_cnt_r < pivff_pkg::CNT_W'(pivff_pkg::DIV_STEPS))
    else $error("divide step counter out of range");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == pivff_pkg::S_EMIT)
    else $error("result raised outside emit state");

  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> state_r == pivff_pkg::S_IDLE && out_valid_r)
    else $error("emit did not publish result");

endmodule

FILE: hw/rtl/pi_voltage_loop_with_feedforward.sv
// Incremental PI voltage loop with ratio feed-forward, top level.
// A new input transaction is accepted only in the idle state, after the previous one has
// been emitted; the 35-step restoring divider is skipped when bus is 0 or the quotient
// would overflow its range.
// A result waiting in the output register does not block the next input.
// Reset (rst_n, synchronous, low): config registers to defaults, error and accumulator to 0.
module pi_voltage_loop_with_feedforward (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [pivff_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pivff_pkg::GAIN_W-1:0]    cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pivff_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pivff_pkg::out_item_t            out_data
);

  pivff_pkg::cmd_t    cmd;
  pivff_pkg::status_t status;

  pivff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pivff_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

FILE: tb/tb_pi_voltage_loop_with_feedforward.sv
// Testbench for pi_voltage_loop_with_feedforward: directed and random transactions,
// checked against a cycle-free duty predictor kept in step with every accepted input.
// Depends on pivff_pkg and the pi_voltage_loop_with_feedforward RTL only.
module tb_pi_voltage_loop_with_feedforward;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     LATENCY     = 50;
  localparam longint CYCLE_LIMIT = 1_000_000;
  localparam longint PROD_CAP    = longint'(1) << 61;
  localparam longint FF_CAP_CNT  = longint'(1) << 18;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  pivff_pkg::cfg_idx_t   cfg_index = pivff_pkg::CFG_PROP_GAIN;
  logic [31:0]           cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pivff_pkg::in_item_t   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pivff_pkg::out_item_t  out_data;

  // predictor copy of configuration and loop state
  logic [31:0] kp_reg = pivff_pkg::KP_RST;
  logic [31:0] ki_reg = pivff_pkg::KI_RST;
  logic [15:0] lim_reg = pivff_pkg::LIM_RST;
  logic [15:0] per_reg = pivff_pkg::PER_RST;
  longint      err_prev = 0;
  longint      pi_acc = 0;

  pivff_pkg::out_item_t duty_q[$];
  int          mismatch_cnt = 0;
  int          items_sent = 0;
  int          loop_hits = 0;
  int          duty_hits = 0;
  int          settings_cnt = 0;
  longint      cycle_cnt = 0;

  int          burst_left = 0;
  int          gap_max = 4;
  bit          no_idle = 1'b0;
  int          stall_pct = 30;
  int          stall_max = 10;
  int          stall_run = 0;

  pi_voltage_loop_with_feedforward DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, duty_q.size());
      $display("tb_pi_voltage_loop_with_feedforward: errors");
      $finish;
    end
  end

  // receiver stall pattern: runs of random length, density set per phase
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_run <= $urandom_range(1, stall_max);
      out_stall <= !no_idle && ($urandom_range(0, 99) < stall_pct);
    end else begin
      stall_run <= stall_run - 1;
      if (no_idle) out_stall <= 1'b0;
    end
  end

  function automatic longint gain_product(input logic [31:0] gain, input longint x);
    longint g;
    longint p;
    g = gain;
    p = g * x;
    if (p > PROD_CAP) p = PROD_CAP;
    else if (p < -PROD_CAP) p = -PROD_CAP;
    return p;
  endfunction

  function automatic pivff_pkg::out_item_t predict_duty(input pivff_pkg::in_item_t it);
    pivff_pkg::out_item_t res;
    longint rv, fv, bv, err, prod, acc, lim, per_cnt, period, ff, num, q, r, tot;
    res = '0;
    rv = it.ref_voltage;
    fv = it.feedback_voltage;
    bv = it.bus_voltage;
    err = rv - fv;
    prod = gain_product(kp_reg, err - err_prev) + gain_product(ki_reg, err);
    acc = pi_acc + (prod >>> pivff_pkg::GAIN_SHR);
    lim = lim_reg;
    lim = lim << pivff_pkg::ACC_FRAC;
    if (acc > lim) begin
      acc = lim;
      res.loop_clamped = 1'b1;
    end else if (acc < -lim) begin
      acc = -lim;
      res.loop_clamped = 1'b1;
    end
    err_prev = err;
    pi_acc = acc;

    per_cnt = per_reg;
    period = per_cnt << pivff_pkg::ACC_FRAC;
    if (bv == 0) begin
      ff = period;
    end else begin
      num = per_cnt * rv;
      q = num / bv;
      r = num % bv;
      if (q > FF_CAP_CNT) ff = FF_CAP_CNT << pivff_pkg::ACC_FRAC;
      else ff = (q << pivff_pkg::ACC_FRAC) + ((r << pivff_pkg::ACC_FRAC) / bv);
    end

    tot = acc + ff;
    if (tot > period) begin
      tot = period;
      res.duty_clamped = 1'b1;
    end else if (tot < 0) begin
      tot = 0;
      res.duty_clamped = 1'b1;
    end
    res.duty_count = 16'(tot >>> pivff_pkg::ACC_FRAC);
    return res;
  endfunction

  always @(posedge clk) begin
    pivff_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (duty_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: duty %0d loop_clamped %0b duty_clamped %0b",
                   out_data.duty_count, out_data.loop_clamped, out_data.duty_clamped);
      end else begin
        want = duty_q.pop_front();
        if (out_data.duty_count !== want.duty_count ||
            out_data.loop_clamped !== want.loop_clamped ||
            out_data.duty_clamped !== want.duty_clamped) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"mismatch at cycle %0d: duty exp %0d act %0d, ",
                      "loop_clamped exp %0b act %0b, duty_clamped exp %0b act %0b"},
                     cycle_cnt, want.duty_count, out_data.duty_count,
                     want.loop_clamped, out_data.loop_clamped,
                     want.duty_clamped, out_data.duty_clamped);
        end
      end
    end
  end

  task automatic send_item(input pivff_pkg::in_item_t it);
    int gap;
    pivff_pkg::out_item_t res;
    if (burst_left == 0) begin
      gap = no_idle ? 0 : $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_duty(it);
    duty_q.push_back(res);
    items_sent++;
    loop_hits += res.loop_clamped;
    duty_hits += res.duty_clamped;
  endtask

  task automatic send_vals(input int rv, input int fv, input int bv);
    pivff_pkg::in_item_t it;
    it.ref_voltage = 16'(rv);
    it.feedback_voltage = 16'(fv);
    it.bus_voltage = 16'(bv);
    send_item(it);
  endtask

  // drop valid, wait for all outstanding results, then let the datapath settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (duty_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [15:0] lim, input logic [15:0] per);
    pivff_pkg::cfg_idx_t order[4];
    logic [31:0]         vals[4];
    order = '{pivff_pkg::CFG_PROP_GAIN, pivff_pkg::CFG_INT_GAIN,
              pivff_pkg::CFG_CTRL_LIMIT, pivff_pkg::CFG_PWM_PERIOD};
    // upper half of the write data for the 16-bit registers carries junk that must be dropped
    vals = '{kp, ki, {16'($urandom), lim}, {16'($urandom), per}};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (order[i])
        pivff_pkg::CFG_PROP_GAIN:  kp_reg = vals[i];
        pivff_pkg::CFG_INT_GAIN:   ki_reg = vals[i];
        pivff_pkg::CFG_CTRL_LIMIT: lim_reg = vals[i][15:0];
        pivff_pkg::CFG_PWM_PERIOD: per_reg = vals[i][15:0];
      endcase
    end
    cfg_wr_en <= 1'b0;
    settings_cnt++;
  endtask

  function automatic logic [15:0] clip16(input int v);
    return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic logic [15:0] edge16();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // reset values; first item sees zero accumulator so ref == bus lands exactly on the period
  task automatic test_reset_defaults();
    send_vals(500, 500, 500);
    send_vals(1000, 900, 2000);
    send_vals(1000, 1100, 2000);
    send_vals(65535, 0, 65535);
    send_vals(0, 65535, 65535);
    send_vals(65535, 65535, 1);
  endtask

  task automatic test_ff_special_cases();
    send_vals(0, 0, 0);
    send_vals(65535, 40000, 0);
    send_vals(65535, 65535, 1);
    send_vals(32768, 32768, 125);
    send_vals(32768, 32768, 124);
  endtask

  task automatic test_zero_limit();
    apply_settings(pivff_pkg::KP_RST, pivff_pkg::KI_RST, 16'd0, pivff_pkg::PER_RST);
    send_vals(4000, 3000, 5000);
    send_vals(700, 700, 700);
    send_vals(0, 65535, 0);
    send_vals(0, 65535, 65535);
  endtask

  task automatic test_register_extremes();
    apply_settings('1, '1, 16'hFFFF, 16'hFFFF);
    send_vals(65535, 0, 65535);
    send_vals(0, 65535, 1);
    send_vals(30000, 30001, 60000);
    apply_settings('0, '0, 16'hFFFF, 16'd0);
    send_vals(65535, 0, 1);
    send_vals(0, 65535, 0);
    apply_settings('1, '0, 16'd1, 16'hFFFF);
    send_vals(100, 99, 200);
    send_vals(99, 100, 200);
  endtask

  task automatic test_random_traffic();
    pivff_pkg::in_item_t it;
    logic [31:0] kp, ki;
    logic [15:0] lim, per;
    int          pick, setpoint;
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 3))
        0:       kp = '0;
        1:       kp = $urandom_range(0, 32'h0200_0000);
        2:       kp = $urandom;
        default: kp = '1;
      endcase
      case ($urandom_range(0, 3))
        0:       ki = '0;
        1:       ki = $urandom_range(0, 32'h0010_0000);
        2:       ki = $urandom;
        default: ki = '1;
      endcase
      case ($urandom_range(0, 3))
        0:       lim = '0;
        1:       lim = '1;
        2:       lim = 16'($urandom_range(1, 200));
        default: lim = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       per = 16'($urandom_range(0, 20));
        1:       per = '1;
        2:       per = 16'($urandom_range(100, 5000));
        default: per = 16'($urandom);
      endcase
      if (p == 0) begin
        kp = pivff_pkg::KP_RST;
        ki = pivff_pkg::KI_RST;
        lim = pivff_pkg::LIM_RST;
        per = pivff_pkg::PER_RST;
      end
      apply_settings(kp, ki, lim, per);
      no_idle = (p % 4 == 1);
      gap_max = (p % 3 == 0) ? 60 : 4;
      stall_pct = (p % 4) * 30;
      stall_max = (p % 3 == 2) ? 70 : 10;
      setpoint = $urandom_range(0, 65535);
      for (int n = 0; n < 95; n++) begin
        if ($urandom_range(0, 31) == 0) setpoint = $urandom_range(0, 65535);
        pick = $urandom_range(0, 99);
        it.ref_voltage = 16'($urandom);
        it.feedback_voltage = 16'($urandom);
        it.bus_voltage = 16'($urandom);
        if (pick < 55) begin
          it.ref_voltage = 16'(setpoint);
          it.feedback_voltage = clip16(setpoint + int'($urandom_range(0, 400)) - 200);
          it.bus_voltage = clip16(setpoint + int'($urandom_range(1, 2 * setpoint + 1)));
        end else if (pick < 65) begin
          it.bus_voltage = '0;
        end else if (pick < 80) begin
          it.ref_voltage = edge16();
          it.feedback_voltage = edge16();
          it.bus_voltage = edge16();
        end
        if (p % 2 == 0 && n == 47) wait_idle();
        send_item(it);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_ff_special_cases();
    test_zero_limit();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    $display("summary: %0d transactions under %0d register settings written after reset",
             items_sent, settings_cnt);
    $display("summary: %0d accumulator clamps and %0d duty clamps predicted, %0d mismatches",
             loop_hits, duty_hits, mismatch_cnt);
    if (mismatch_cnt == 0 && duty_q.size() == 0) begin
      $display("tb_pi_voltage_loop_with_feedforward: clean");
    end else begin
      $display("tb_pi_voltage_loop_with_feedforward: errors");
    end
    $finish;
  end

endmodule
